// ===== hw/rtl/pst_pkg.sv =====
// Shared types and constants of the pose steering core.
// Used by the square root cell, the divider cell and the top level.
package pst_pkg;

  localparam int unsigned POS_W   = 32;            // position field width
  localparam int unsigned DIFF_W  = POS_W + 1;     // signed difference width
  localparam int unsigned ANG_W   = 16;            // angle field width (full turn)
  localparam int unsigned LEN_W   = 31;            // step_length register width
  localparam int unsigned SANG_W  = 15;            // step_angle register width
  localparam int unsigned SQ_W    = 2 * POS_W + 1; // dx^2 + dy^2
  localparam int unsigned RAD_W   = SQ_W + 1;      // radicand, even width
  localparam int unsigned ROOT_W  = RAD_W / 2;     // root digits, one per cell
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned PROD_W  = POS_W + LEN_W; // |d| * step_length
  localparam int unsigned QUO_W   = POS_W;         // quotient bits, one per cell
  localparam int unsigned DVS_W   = ROOT_W;
  localparam int unsigned LSQ_W   = 2 * LEN_W;
  localparam int unsigned CFG_W   = LEN_W;
  localparam int unsigned IDX_W   = 1;

  localparam logic [IDX_W-1:0] REG_STEP_LENGTH = 1'd0;
  localparam logic [IDX_W-1:0] REG_STEP_ANGLE  = 1'd1;

  localparam logic [LEN_W-1:0]  STEP_LENGTH_RST = 31'd65536;
  localparam logic [SANG_W-1:0] STEP_ANGLE_RST  = 15'd4096;

  // Stage count of the pipeline: front end (3) + root cells + divider cells + output stage.
  localparam int unsigned LATENCY = 3 + ROOT_W + QUO_W + 1;

  typedef struct packed {
    logic signed [POS_W-1:0] near_x;
    logic signed [POS_W-1:0] near_y;
    logic signed [POS_W-1:0] rand_x;
    logic signed [POS_W-1:0] rand_y;
    logic                    neg_x;
    logic                    neg_y;
    logic        [ANG_W-1:0] yaw;
    logic                    bad;
    logic                    limit;
  } item_t;

  typedef struct packed {
    item_t             it;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
  } sq_pay_t;

endpackage

// ===== hw/rtl/pst_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root.
// Depends on pst_pkg for widths and the payload type.
module pst_sqrt_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [pst_pkg::RAD_W-1:0]   rad_i,
  input  logic [pst_pkg::REM_W-1:0]   rem_i,
  input  logic [pst_pkg::ROOT_W-1:0]  root_i,
  input  pst_pkg::sq_pay_t            pay_i,
  output logic                        valid_o,
  output logic [pst_pkg::RAD_W-1:0]   rad_o,
  output logic [pst_pkg::REM_W-1:0]   rem_o,
  output logic [pst_pkg::ROOT_W-1:0]  root_o,
  output pst_pkg::sq_pay_t            pay_o
);

  logic [pst_pkg::REM_W-1:0]  cur;
  logic [pst_pkg::REM_W-1:0]  trial;
  logic                       ge;
  logic                       valid_q;
  logic [pst_pkg::RAD_W-1:0]  rad_d, rad_q;
  logic [pst_pkg::REM_W-1:0]  rem_d, rem_q;
  logic [pst_pkg::ROOT_W-1:0] root_d, root_q;
  pst_pkg::sq_pay_t           pay_q;

  // Bring down the next two radicand bits and try root*4+1.
  assign cur    = {rem_i[pst_pkg::REM_W-3:0], rad_i[pst_pkg::RAD_W-1 -: 2]};
  assign trial  = {root_i, 2'b01};
  assign ge     = (cur >= trial);
  assign rem_d  = ge ? (cur - trial) : cur;
  assign root_d = {root_i[pst_pkg::ROOT_W-2:0], ge};
  assign rad_d  = {rad_i[pst_pkg::RAD_W-3:0], 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    pay_q  <= pay_i;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

// ===== hw/rtl/pst_div_cell.sv =====
// One quotient-bit cell of the pipelined restoring divider, x and y lanes.
// Depends on pst_pkg for widths and the payload type.
module pst_div_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [pst_pkg::DVS_W-1:0]  dvs_i,
  input  logic [pst_pkg::DVS_W-1:0]  rx_i,
  input  logic [pst_pkg::QUO_W-1:0]  lx_i,
  input  logic [pst_pkg::QUO_W-1:0]  qx_i,
  input  logic [pst_pkg::DVS_W-1:0]  ry_i,
  input  logic [pst_pkg::QUO_W-1:0]  ly_i,
  input  logic [pst_pkg::QUO_W-1:0]  qy_i,
  input  pst_pkg::item_t             pay_i,
  output logic                       valid_o,
  output logic [pst_pkg::DVS_W-1:0]  dvs_o,
  output logic [pst_pkg::DVS_W-1:0]  rx_o,
  output logic [pst_pkg::QUO_W-1:0]  lx_o,
  output logic [pst_pkg::QUO_W-1:0]  qx_o,
  output logic [pst_pkg::DVS_W-1:0]  ry_o,
  output logic [pst_pkg::QUO_W-1:0]  ly_o,
  output logic [pst_pkg::QUO_W-1:0]  qy_o,
  output pst_pkg::item_t             pay_o
);

  logic [pst_pkg::DVS_W:0]   tx, ty;
  logic                      gx, gy;
  logic                      valid_q;
  logic [pst_pkg::DVS_W-1:0] dvs_q;
  logic [pst_pkg::DVS_W-1:0] rx_d, rx_q, ry_d, ry_q;
  logic [pst_pkg::QUO_W-1:0] lx_q, ly_q, qx_q, qy_q;
  pst_pkg::item_t            pay_q;

  // Shift in the next dividend bit, subtract the divisor if it fits.
  assign tx   = {rx_i, lx_i[pst_pkg::QUO_W-1]};
  assign ty   = {ry_i, ly_i[pst_pkg::QUO_W-1]};
  assign gx   = (tx >= {1'b0, dvs_i});
  assign gy   = (ty >= {1'b0, dvs_i});
  assign rx_d = gx ? pst_pkg::DVS_W'(tx - {1'b0, dvs_i}) : pst_pkg::DVS_W'(tx);
  assign ry_d = gy ? pst_pkg::DVS_W'(ty - {1'b0, dvs_i}) : pst_pkg::DVS_W'(ty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_i;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    lx_q  <= {lx_i[pst_pkg::QUO_W-2:0], 1'b0};
    ly_q  <= {ly_i[pst_pkg::QUO_W-2:0], 1'b0};
    qx_q  <= {qx_i[pst_pkg::QUO_W-2:0], gx};
    qy_q  <= {qy_i[pst_pkg::QUO_W-2:0], gy};
    pay_q <= pay_i;
  end

  assign valid_o = valid_q;
  assign dvs_o   = dvs_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign lx_o    = lx_q;
  assign ly_o    = ly_q;
  assign qx_o    = qx_q;
  assign qy_o    = qy_q;
  assign pay_o   = pay_q;

endmodule

// ===== hw/rtl/rrt_pose_steering_core.sv =====
// Pose steering core: front end, square root cell chain, divider cell chain.
// Depends on pst_pkg, pst_sqrt_cell and pst_div_cell.
//
// Usage: drive a nearest pose and a random pose on the near_* and rand_*
// ports and raise start_i; the item is taken at every edge where start_i is
// high and busy_o low. busy_o stays low, so a new item may enter every cycle.
// Each item yields one result on steer_x_o, steer_y_o, steer_yaw_o and
// bad_config_o, shown for exactly one cycle with valid_o high, in order.
// The pipeline has three front-end stages (difference, squares and
// products, sum and limit compare), 33 root cells, 32 divider cells and an
// output register. Throughput is one item per cycle, set by the cell chains.
// Step registers are written through cfg_we_i, cfg_idx_i and cfg_data_i and
// must only change while no item is in flight. A zero step register makes
// the result carry bad_config_o high and zero pose fields.
// Reset clears the pipeline valid bits and loads the default step values.
// The receiver cannot stall; results must be taken when valid_o is high.
module rrt_pose_steering_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [pst_pkg::POS_W-1:0]  near_x_i,
  input  logic signed [pst_pkg::POS_W-1:0]  near_y_i,
  input  logic signed [pst_pkg::ANG_W-1:0]  near_yaw_i,
  input  logic signed [pst_pkg::POS_W-1:0]  rand_x_i,
  input  logic signed [pst_pkg::POS_W-1:0]  rand_y_i,
  input  logic signed [pst_pkg::ANG_W-1:0]  rand_yaw_i,
  input  logic                              cfg_we_i,
  input  logic [pst_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [pst_pkg::CFG_W-1:0]         cfg_data_i,
  output logic                              valid_o,
  output logic signed [pst_pkg::POS_W-1:0]  steer_x_o,
  output logic signed [pst_pkg::POS_W-1:0]  steer_y_o,
  output logic signed [pst_pkg::ANG_W-1:0]  steer_yaw_o,
  output logic                              bad_config_o
);

  localparam int unsigned NR = pst_pkg::ROOT_W;
  localparam int unsigned ND = pst_pkg::QUO_W;

  // ---------------- configuration ----------------
  logic [pst_pkg::LEN_W-1:0]  step_length_q;
  logic [pst_pkg::SANG_W-1:0] step_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_length_q <= pst_pkg::STEP_LENGTH_RST;
      step_angle_q  <= pst_pkg::STEP_ANGLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pst_pkg::REG_STEP_LENGTH: step_length_q <= cfg_data_i;
        pst_pkg::REG_STEP_ANGLE:  step_angle_q  <= cfg_data_i[pst_pkg::SANG_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // ---------------- stage 1: differences and heading ----------------
  logic                               accept;
  logic signed [pst_pkg::DIFF_W-1:0]  dx, dy;
  logic [pst_pkg::POS_W-1:0]          mx, my;
  logic [pst_pkg::ANG_W-1:0]          da;
  logic [pst_pkg::ANG_W:0]            abs_da;
  logic [pst_pkg::ANG_W-1:0]          yaw_d;
  pst_pkg::item_t                     it1_d;

  assign accept = start_i && !busy_o;
  assign dx = pst_pkg::DIFF_W'(rand_x_i) - pst_pkg::DIFF_W'(near_x_i);
  assign dy = pst_pkg::DIFF_W'(rand_y_i) - pst_pkg::DIFF_W'(near_y_i);
  assign mx = dx[pst_pkg::DIFF_W-1] ? pst_pkg::POS_W'(-dx) : pst_pkg::POS_W'(dx);
  assign my = dy[pst_pkg::DIFF_W-1] ? pst_pkg::POS_W'(-dy) : pst_pkg::POS_W'(dy);

  // Half a turn counts as negative: two's-complement wrap does that for free.
  assign da     = rand_yaw_i - near_yaw_i;
  assign abs_da = da[pst_pkg::ANG_W-1] ? ((pst_pkg::ANG_W+1)'(0) - {1'b1, da})
                                       : {1'b0, da};

  always_comb begin
    yaw_d = rand_yaw_i;
    if (abs_da > (pst_pkg::ANG_W+1)'(step_angle_q)) begin
      yaw_d = da[pst_pkg::ANG_W-1]
            ? near_yaw_i - pst_pkg::ANG_W'(step_angle_q)
            : near_yaw_i + pst_pkg::ANG_W'(step_angle_q);
    end
  end

  always_comb begin
    it1_d.near_x = near_x_i;
    it1_d.near_y = near_y_i;
    it1_d.rand_x = rand_x_i;
    it1_d.rand_y = rand_y_i;
    it1_d.neg_x  = dx[pst_pkg::DIFF_W-1];
    it1_d.neg_y  = dy[pst_pkg::DIFF_W-1];
    it1_d.yaw    = yaw_d;
    it1_d.bad    = (step_length_q == '0) || (step_angle_q == '0);
    it1_d.limit  = 1'b0;
  end

  logic                      v1_q;
  pst_pkg::item_t            it1_q;
  logic [pst_pkg::POS_W-1:0] mx_q, my_q;

  // ---------------- stage 2: squares and products ----------------
  logic                       v2_q;
  pst_pkg::item_t             it2_q;
  logic [2*pst_pkg::POS_W-1:0] sqx_q, sqy_q;
  logic [pst_pkg::PROD_W-1:0] prx_q, pry_q;
  logic [pst_pkg::LSQ_W-1:0]  lsq_q;

  // ---------------- stage 3: sum and limit test ----------------
  logic                       v3_q;
  pst_pkg::item_t             it3_d, it3_q;
  logic [pst_pkg::SQ_W-1:0]   sum_d, sum3_q;
  logic [pst_pkg::PROD_W-1:0] prx3_q, pry3_q;

  assign sum_d = pst_pkg::SQ_W'(sqx_q) + pst_pkg::SQ_W'(sqy_q);

  always_comb begin
    it3_d       = it2_q;
    it3_d.limit = (sum_d > pst_pkg::SQ_W'(lsq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    it1_q <= it1_d;
    mx_q  <= mx;
    my_q  <= my;

    it2_q <= it1_q;
    sqx_q <= mx_q * mx_q;
    sqy_q <= my_q * my_q;
    prx_q <= pst_pkg::PROD_W'(mx_q) * pst_pkg::PROD_W'(step_length_q);
    pry_q <= pst_pkg::PROD_W'(my_q) * pst_pkg::PROD_W'(step_length_q);
    lsq_q <= step_length_q * step_length_q;

    it3_q  <= it3_d;
    sum3_q <= sum_d;
    prx3_q <= prx_q;
    pry3_q <= pry_q;
  end

  // ---------------- square root cell chain ----------------
  logic                       sv [NR+1];
  logic [pst_pkg::RAD_W-1:0]  srad [NR+1];
  logic [pst_pkg::REM_W-1:0]  srem [NR+1];
  logic [pst_pkg::ROOT_W-1:0] sroot [NR+1];
  pst_pkg::sq_pay_t           spay [NR+1];

  assign sv[0]           = v3_q;
  assign srad[0]         = pst_pkg::RAD_W'(sum3_q);
  assign srem[0]         = '0;
  assign sroot[0]        = '0;
  assign spay[0].it      = it3_q;
  assign spay[0].prod_x  = prx3_q;
  assign spay[0].prod_y  = pry3_q;

  for (genvar i = 0; i < NR; i++) begin : g_root
    pst_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[i]),
      .rad_i   (srad[i]),
      .rem_i   (srem[i]),
      .root_i  (sroot[i]),
      .pay_i   (spay[i]),
      .valid_o (sv[i+1]),
      .rad_o   (srad[i+1]),
      .rem_o   (srem[i+1]),
      .root_o  (sroot[i+1]),
      .pay_o   (spay[i+1])
    );
  end

  // ---------------- divider cell chain ----------------
  logic                      dv [ND+1];
  logic [pst_pkg::DVS_W-1:0] ddvs [ND+1];
  logic [pst_pkg::DVS_W-1:0] drx [ND+1], dry [ND+1];
  logic [pst_pkg::QUO_W-1:0] dlx [ND+1], dly [ND+1];
  logic [pst_pkg::QUO_W-1:0] dqx [ND+1], dqy [ND+1];
  pst_pkg::item_t            dpay [ND+1];

  // A zero root only occurs on the unlimited path; hold the divisor at one.
  assign dv[0]   = sv[NR];
  assign ddvs[0] = (sroot[NR] == '0) ? pst_pkg::DVS_W'(1) : sroot[NR];
  assign drx[0]  = pst_pkg::DVS_W'(spay[NR].prod_x[pst_pkg::PROD_W-1:pst_pkg::QUO_W]);
  assign dry[0]  = pst_pkg::DVS_W'(spay[NR].prod_y[pst_pkg::PROD_W-1:pst_pkg::QUO_W]);
  assign dlx[0]  = spay[NR].prod_x[pst_pkg::QUO_W-1:0];
  assign dly[0]  = spay[NR].prod_y[pst_pkg::QUO_W-1:0];
  assign dqx[0]  = '0;
  assign dqy[0]  = '0;
  assign dpay[0] = spay[NR].it;

  for (genvar j = 0; j < ND; j++) begin : g_div
    pst_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[j]),
      .dvs_i   (ddvs[j]),
      .rx_i    (drx[j]),
      .lx_i    (dlx[j]),
      .qx_i    (dqx[j]),
      .ry_i    (dry[j]),
      .ly_i    (dly[j]),
      .qy_i    (dqy[j]),
      .pay_i   (dpay[j]),
      .valid_o (dv[j+1]),
      .dvs_o   (ddvs[j+1]),
      .rx_o    (drx[j+1]),
      .lx_o    (dlx[j+1]),
      .qx_o    (dqx[j+1]),
      .ry_o    (dry[j+1]),
      .ly_o    (dly[j+1]),
      .qy_o    (dqy[j+1]),
      .pay_o   (dpay[j+1])
    );
  end

  // ---------------- output stage ----------------
  pst_pkg::item_t                    fin;
  logic signed [pst_pkg::POS_W+1:0]  vx, vy;
  logic signed [pst_pkg::POS_W-1:0]  satx, saty;
  logic signed [pst_pkg::POS_W-1:0]  x_d, y_d;
  logic signed [pst_pkg::ANG_W-1:0]  yaw_o_d;

  localparam logic signed [pst_pkg::POS_W-1:0] POS_MAX = {1'b0, {(pst_pkg::POS_W-1){1'b1}}};
  localparam logic signed [pst_pkg::POS_W-1:0] POS_MIN = {1'b1, {(pst_pkg::POS_W-1){1'b0}}};

  assign fin = dpay[ND];
  assign vx  = fin.neg_x ? ((pst_pkg::POS_W+2)'(fin.near_x) - (pst_pkg::POS_W+2)'(dqx[ND]))
                         : ((pst_pkg::POS_W+2)'(fin.near_x) + (pst_pkg::POS_W+2)'(dqx[ND]));
  assign vy  = fin.neg_y ? ((pst_pkg::POS_W+2)'(fin.near_y) - (pst_pkg::POS_W+2)'(dqy[ND]))
                         : ((pst_pkg::POS_W+2)'(fin.near_y) + (pst_pkg::POS_W+2)'(dqy[ND]));

  always_comb begin
    satx = pst_pkg::POS_W'(vx);
    saty = pst_pkg::POS_W'(vy);
    if (vx[pst_pkg::POS_W+1:pst_pkg::POS_W-1] != '0 &&
        vx[pst_pkg::POS_W+1:pst_pkg::POS_W-1] != '1) begin
      satx = vx[pst_pkg::POS_W+1] ? POS_MIN : POS_MAX;
    end
    if (vy[pst_pkg::POS_W+1:pst_pkg::POS_W-1] != '0 &&
        vy[pst_pkg::POS_W+1:pst_pkg::POS_W-1] != '1) begin
      saty = vy[pst_pkg::POS_W+1] ? POS_MIN : POS_MAX;
    end
    x_d     = fin.limit ? satx : fin.rand_x;
    y_d     = fin.limit ? saty : fin.rand_y;
    yaw_o_d = fin.yaw;
    if (fin.bad) begin
      x_d     = '0;
      y_d     = '0;
      yaw_o_d = '0;
    end
  end

  logic                             vo_q;
  logic signed [pst_pkg::POS_W-1:0] x_q, y_q;
  logic signed [pst_pkg::ANG_W-1:0] yaw_q;
  logic                             bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= dv[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    yaw_q <= yaw_o_d;
    bad_q <= fin.bad;
  end

  assign valid_o      = vo_q;
  assign steer_x_o    = x_q;
  assign steer_y_o    = y_q;
  assign steer_yaw_o  = yaw_q;
  assign bad_config_o = bad_q;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, pst_pkg::LATENCY))
    else $error("result without matching accepted item");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && bad_config_o) |-> (steer_x_o == '0 && steer_y_o == '0 && steer_yaw_o == '0))
    else $error("bad configuration result carries a pose");

  a_limit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && it3_q.limit) |-> (sum3_q != '0))
    else $error("limited move with zero distance");

endmodule
